[sv/record_fifo_with_search_max_top_assert.svh]
// assertion macros for the record queue, clocked on clk and disabled in reset
`ifndef RECORD_FIFO_WITH_SEARCH_MAX_TOP_ASSERT_SVH
`define RECORD_FIFO_WITH_SEARCH_MAX_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define RFS_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define RFS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define RFS_ASSERT_SAME(lbl, ante, cons, msg)
`define RFS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

[sv/rfs_pkg.sv]
package rfs_pkg;

	localparam int DEPTH = 16;
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	localparam logic signed [15:0] SCORE_FLOOR = -16'sd1000;

	typedef enum logic [1:0] {
		ACT_PUSH   = 2'd0,
		ACT_POP    = 2'd1,
		ACT_SEARCH = 2'd2,
		ACT_NOP    = 2'd3
	} act_t;

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_EMPTY     = 2'd1,
		STAT_FULL      = 2'd2,
		STAT_NOT_FOUND = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_PUSH,
		S_POP_RD,
		S_POP,
		S_SUM_INIT,
		S_SUM,
		S_EMIT,
		S_SRCH_INIT,
		S_SRCH,
		S_FLUSH
	} state_t;

	typedef struct packed {
		act_t               action;
		logic [31:0]        key;
		logic signed [15:0] score;
	} req_t;

	typedef struct packed {
		status_t            status;
		logic [31:0]        item_key;
		logic signed [15:0] item_score;
		logic [4:0]         position;
		logic [31:0]        head_key;
		logic [31:0]        tail_key;
		logic               is_empty;
		logic [4:0]         entry_count;
		logic signed [15:0] max_score;
		logic               last;
	} rsp_t;

	typedef struct packed {
		logic    cap;
		logic    item_init;
		status_t item_status;
		logic    push;
		logic    rd_head;
		logic    pop;
		logic    scan_clr;
		logic    scan_sum;
		logic    scan_srch;
		logic    emit_item;
		logic    flush;
	} ctrl_cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
		logic scan_done;
		logic out_free;
	} ctrl_sts_t;

endpackage

[sv/rfs_ctrl.sv]
module rfs_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_stall,
	input  rfs_pkg::act_t         action,
	input  rfs_pkg::ctrl_sts_t    sts,
	output rfs_pkg::ctrl_cmd_t    cmd
);

	rfs_pkg::state_t state_q, state_d;
	logic            srch_q, srch_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rfs_pkg::S_IDLE;
			srch_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			srch_q  <= srch_d;
		end
	end

	assign req_stall = (state_q != rfs_pkg::S_IDLE);

	always_comb begin
		state_d         = state_q;
		srch_d          = srch_q;
		cmd             = '0;
		cmd.item_status = rfs_pkg::STAT_OK;
		case (state_q)
			rfs_pkg::S_IDLE: begin
				if (req_valid) begin
					cmd.cap       = 1'b1;
					cmd.item_init = 1'b1;
					srch_d        = 1'b0;
					state_d       = rfs_pkg::S_SUM_INIT;
					case (action)
						rfs_pkg::ACT_PUSH: begin
							if (sts.full) begin
								cmd.item_status = rfs_pkg::STAT_FULL;
							end else begin
								state_d = rfs_pkg::S_PUSH;
							end
						end
						rfs_pkg::ACT_POP: begin
							if (sts.empty) begin
								cmd.item_status = rfs_pkg::STAT_EMPTY;
							end else begin
								state_d = rfs_pkg::S_POP_RD;
							end
						end
						rfs_pkg::ACT_SEARCH: begin
							if (sts.empty) begin
								cmd.item_status = rfs_pkg::STAT_EMPTY;
							end else begin
								srch_d = 1'b1;
							end
						end
						default: begin
						end
					endcase
				end
			end
			rfs_pkg::S_PUSH: begin
				cmd.push = 1'b1;
				state_d  = rfs_pkg::S_SUM_INIT;
			end
			rfs_pkg::S_POP_RD: begin
				cmd.rd_head = 1'b1;
				state_d     = rfs_pkg::S_POP;
			end
			rfs_pkg::S_POP: begin
				cmd.pop = 1'b1;
				state_d = rfs_pkg::S_SUM_INIT;
			end
			rfs_pkg::S_SUM_INIT: begin
				cmd.scan_clr = 1'b1;
				state_d      = rfs_pkg::S_SUM;
			end
			rfs_pkg::S_SUM: begin
				cmd.scan_sum = 1'b1;
				if (sts.scan_done) begin
					state_d = srch_q ? rfs_pkg::S_SRCH_INIT : rfs_pkg::S_EMIT;
				end
			end
			rfs_pkg::S_EMIT: begin
				cmd.emit_item = 1'b1;
				if (sts.out_free) begin
					state_d = rfs_pkg::S_IDLE;
				end
			end
			rfs_pkg::S_SRCH_INIT: begin
				cmd.scan_clr = 1'b1;
				state_d      = rfs_pkg::S_SRCH;
			end
			rfs_pkg::S_SRCH: begin
				cmd.scan_srch = 1'b1;
				if (sts.scan_done) begin
					state_d = rfs_pkg::S_FLUSH;
				end
			end
			rfs_pkg::S_FLUSH: begin
				cmd.flush = 1'b1;
				if (sts.out_free) begin
					state_d = rfs_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = rfs_pkg::S_IDLE;
			end
		endcase
	end

endmodule

[sv/rfs_dp.sv]
module rfs_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  rfs_pkg::req_t      req,
	input  rfs_pkg::ctrl_cmd_t cmd,
	output rfs_pkg::ctrl_sts_t sts,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output rfs_pkg::rsp_t      rsp
);

	localparam int PW = rfs_pkg::PTR_W;
	localparam int CW = rfs_pkg::CNT_W;

	logic [31:0]        key_mem [rfs_pkg::DEPTH];
	logic signed [15:0] score_mem [rfs_pkg::DEPTH];

	logic [PW-1:0]      head_q, tail_q;
	logic [CW-1:0]      occ_q;
	logic [31:0]        in_key_q;
	logic signed [15:0] in_score_q;

	rfs_pkg::status_t   item_status_q;
	logic [31:0]        item_key_q;
	logic signed [15:0] item_score_q;

	logic [31:0]        rd_key_q;
	logic signed [15:0] rd_score_q;
	logic [CW-1:0]      idx_q, off_q;
	logic               dv_q;

	logic [31:0]        sum_head_q, sum_tail_q;
	logic signed [15:0] sum_max_q;

	logic               pend_valid_q;
	logic [31:0]        pend_key_q;
	logic signed [15:0] pend_score_q;
	logic [CW-1:0]      pend_pos_q;

	rfs_pkg::rsp_t      out_q;
	logic               out_valid_q;

	logic               out_free, match, scan_active, hold, issue, promote, take, rd_en;
	logic               load;
	rfs_pkg::rsp_t      load_val;
	logic [PW:0]        addr_sum, addr_wrap;
	logic [PW-1:0]      rd_addr;

	function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
		return (p == PW'(rfs_pkg::DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign out_free    = !out_valid_q || !rsp_stall;
	assign match       = (rd_key_q == in_key_q);
	assign scan_active = cmd.scan_sum || cmd.scan_srch;
	assign hold        = cmd.scan_srch && dv_q && match && pend_valid_q && !out_free;
	assign promote     = cmd.scan_srch && dv_q && match && pend_valid_q && out_free;
	assign take        = cmd.scan_srch && dv_q && match && !hold;
	assign issue       = scan_active && !hold && (idx_q < occ_q);
	assign rd_en       = issue || cmd.rd_head;

	// slot of scan offset, wrapped at the queue depth
	assign addr_sum  = {1'b0, head_q} + (PW+1)'(idx_q);
	assign addr_wrap = (addr_sum >= (PW+1)'(rfs_pkg::DEPTH)) ?
		addr_sum - (PW+1)'(rfs_pkg::DEPTH) : addr_sum;
	assign rd_addr   = cmd.rd_head ? head_q : addr_wrap[PW-1:0];

	assign sts.full      = (occ_q == CW'(rfs_pkg::DEPTH));
	assign sts.empty     = (occ_q == '0);
	assign sts.scan_done = scan_active && !dv_q && (idx_q >= occ_q);
	assign sts.out_free  = out_free;

	always_comb begin
		load                 = 1'b0;
		load_val.status      = rfs_pkg::STAT_OK;
		load_val.item_key    = '0;
		load_val.item_score  = '0;
		load_val.position    = '0;
		load_val.head_key    = sum_head_q;
		load_val.tail_key    = sum_tail_q;
		load_val.is_empty    = (occ_q == '0);
		load_val.entry_count = 5'(occ_q);
		load_val.max_score   = sum_max_q;
		load_val.last        = 1'b1;
		if (promote) begin
			// an earlier match goes out once a later one shows up
			load                = 1'b1;
			load_val.item_key   = pend_key_q;
			load_val.item_score = pend_score_q;
			load_val.position   = 5'(pend_pos_q);
			load_val.last       = 1'b0;
		end else if (cmd.emit_item && out_free) begin
			load                = 1'b1;
			load_val.status     = item_status_q;
			load_val.item_key   = item_key_q;
			load_val.item_score = item_score_q;
		end else if (cmd.flush && out_free) begin
			load = 1'b1;
			if (pend_valid_q) begin
				load_val.item_key   = pend_key_q;
				load_val.item_score = pend_score_q;
				load_val.position   = 5'(pend_pos_q);
			end else begin
				load_val.status = rfs_pkg::STAT_NOT_FOUND;
			end
		end
	end

	// record memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			key_mem[tail_q]   <= in_key_q;
			score_mem[tail_q] <= in_score_q;
		end
		if (rd_en) begin
			rd_key_q   <= key_mem[rd_addr];
			rd_score_q <= score_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q       <= '0;
			tail_q       <= '0;
			occ_q        <= '0;
			idx_q        <= '0;
			dv_q         <= 1'b0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cmd.push) begin
				tail_q <= ptr_inc(tail_q);
				occ_q  <= occ_q + 1'b1;
			end
			if (cmd.pop) begin
				head_q <= ptr_inc(head_q);
				occ_q  <= occ_q - 1'b1;
			end
			if (cmd.scan_clr) begin
				idx_q        <= '0;
				dv_q         <= 1'b0;
				pend_valid_q <= 1'b0;
			end else begin
				if (issue) begin
					idx_q <= idx_q + 1'b1;
					dv_q  <= 1'b1;
				end else if (scan_active && !hold) begin
					dv_q <= 1'b0;
				end
				if (take) begin
					pend_valid_q <= 1'b1;
				end else if (cmd.flush && out_free) begin
					pend_valid_q <= 1'b0;
				end
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			in_key_q   <= req.key;
			in_score_q <= req.score;
		end
		if (cmd.item_init) begin
			item_status_q <= cmd.item_status;
			item_key_q    <= '0;
			item_score_q  <= '0;
		end
		if (cmd.push) begin
			item_key_q   <= in_key_q;
			item_score_q <= in_score_q;
		end
		if (cmd.pop) begin
			item_key_q   <= rd_key_q;
			item_score_q <= rd_score_q;
		end
		if (issue) begin
			off_q <= idx_q;
		end
		// summary survives the second scan of a search
		if (cmd.item_init) begin
			sum_head_q <= '0;
			sum_tail_q <= '0;
			sum_max_q  <= rfs_pkg::SCORE_FLOOR;
		end else if (cmd.scan_sum && dv_q) begin
			if (off_q == '0) begin
				sum_head_q <= rd_key_q;
			end
			if (off_q == occ_q - 1'b1) begin
				sum_tail_q <= rd_key_q;
			end
			if (rd_score_q > sum_max_q) begin
				sum_max_q <= rd_score_q;
			end
		end
		if (take) begin
			pend_key_q   <= rd_key_q;
			pend_score_q <= rd_score_q;
			pend_pos_q   <= off_q + 1'b1;
		end
		if (load) begin
			out_q <= load_val;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

endmodule

[sv/record_fifo_with_search_max_top.sv]
// record queue with key search and max-score summary, one action per beat
// n = entries held after the step; a push that fits writes the record, a pop on a non-empty
// queue reads and drops the head, then every action scans the n entries for the summary
// search: the read port scans n entries for the summary, then again for the key compare;
// next beat taken in the cycle after the last result loads
// reset: async active low, clears pointers, count and control; memory is only read where written
`include "record_fifo_with_search_max_top_assert.svh"

module record_fifo_with_search_max_top (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  rfs_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output rfs_pkg::rsp_t rsp
);

	rfs_pkg::ctrl_cmd_t cmd;
	rfs_pkg::ctrl_sts_t sts;

	rfs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.action    (req.action),
		.sts       (sts),
		.cmd       (cmd)
	);

	rfs_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.sts       (sts),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	`RFS_ASSERT_NEXT(a_busy_after_beat, req_valid && !req_stall, req_stall, "no stall after beat")
	`RFS_ASSERT_SAME(a_count_bound, rsp_valid, 32'(rsp.entry_count) <= rfs_pkg::DEPTH, "count over depth")
	`RFS_ASSERT_SAME(a_empty_flag, rsp_valid, rsp.is_empty == (rsp.entry_count == 5'd0), "empty flag mismatch")
	`RFS_ASSERT_SAME(a_err_no_pos, rsp_valid && (rsp.status != rfs_pkg::STAT_OK), rsp.position == 5'd0, "position on error")

endmodule

[tb/sv/record_fifo_with_search_max_top_tb.sv]
module record_fifo_with_search_max_top_tb;
	import rfs_pkg::*;

	localparam int CYCLE_LIMIT = 500000;
	localparam int DRAIN_CYCLES = 60;
	localparam int RANDOM_PER_PHASE = 120;

	// mirror of the record queue; every accepted beat appends the results it must cause
	class record_tracker;
		logic [31:0]        key_mem [DEPTH];
		logic signed [15:0] score_mem [DEPTH];
		logic [PTR_W-1:0]   head_slot;
		logic [PTR_W-1:0]   tail_slot;
		logic [CNT_W-1:0]   fill_count;
		rsp_t               due_results[$];
		int                 fail_count;
		int                 checked;
		int                 full_hits;
		int                 absent_hits;
		int                 most_matches;
		int                 action_hits[4];

		function new();
			head_slot = '0;
			tail_slot = '0;
			fill_count = '0;
			fail_count = 0;
			checked = 0;
			full_hits = 0;
			absent_hits = 0;
			most_matches = 0;
			foreach (action_hits[i])
				action_hits[i] = 0;
		endfunction

		// result with item fields zero and the queue summary as it stands now
		function rsp_t blank_result(status_t st);
			rsp_t               r;
			logic [PTR_W-1:0]   slot;
			logic signed [15:0] top;
			r = '0;
			r.status = st;
			top = SCORE_FLOOR;
			if (fill_count != 0) begin
				r.head_key = key_mem[head_slot];
				slot = head_slot + PTR_W'(fill_count - 1);
				r.tail_key = key_mem[slot];
			end
			for (int i = 0; i < fill_count; i++) begin
				slot = head_slot + PTR_W'(i);
				// strictly greater, so scores below the floor never show
				if (score_mem[slot] > top)
					top = score_mem[slot];
			end
			r.is_empty = (fill_count == 0);
			r.entry_count = fill_count;
			r.max_score = top;
			return r;
		endfunction

		function void note_action(req_t item);
			rsp_t               found[$];
			rsp_t               r;
			logic [31:0]        k;
			logic signed [15:0] s;
			logic [PTR_W-1:0]   slot;
			action_hits[item.action]++;
			case (item.action)
				ACT_PUSH: begin
					if (fill_count == CNT_W'(DEPTH)) begin
						found.push_back(blank_result(STAT_FULL));
						full_hits++;
					end else begin
						key_mem[tail_slot] = item.key;
						score_mem[tail_slot] = item.score;
						tail_slot++;
						fill_count++;
						r = blank_result(STAT_OK);
						r.item_key = item.key;
						r.item_score = item.score;
						found.push_back(r);
					end
				end
				ACT_POP: begin
					if (fill_count == 0) begin
						found.push_back(blank_result(STAT_EMPTY));
					end else begin
						k = key_mem[head_slot];
						s = score_mem[head_slot];
						head_slot++;
						fill_count--;
						r = blank_result(STAT_OK);
						r.item_key = k;
						r.item_score = s;
						found.push_back(r);
					end
				end
				ACT_SEARCH: begin
					if (fill_count == 0) begin
						found.push_back(blank_result(STAT_EMPTY));
					end else begin
						for (int i = 0; i < fill_count; i++) begin
							slot = head_slot + PTR_W'(i);
							if (key_mem[slot] == item.key) begin
								r = blank_result(STAT_OK);
								r.item_key = key_mem[slot];
								r.item_score = score_mem[slot];
								r.position = 5'(i + 1);
								found.push_back(r);
							end
						end
						if (found.size() > most_matches)
							most_matches = found.size();
						if (found.size() == 0) begin
							found.push_back(blank_result(STAT_NOT_FOUND));
							absent_hits++;
						end
					end
				end
				default: begin
					found.push_back(blank_result(STAT_OK));
				end
			endcase
			found[found.size() - 1].last = 1'b1;
			foreach (found[i])
				due_results.push_back(found[i]);
		endfunction

		task report_mismatch(string what);
			fail_count++;
			if (fail_count <= 40)
				$display("mismatch: %s", what);
		endtask

		task compare_field(string name, logic [31:0] got, logic [31:0] want);
			if (got !== want)
				report_mismatch($sformatf("result %0d %s: got %h want %h",
					checked, name, got, want));
		endtask

		task check_result(rsp_t got);
			rsp_t want;
			if (due_results.size() == 0) begin
				report_mismatch($sformatf("result with nothing due, status %0d key %h",
					got.status, got.item_key));
				return;
			end
			want = due_results.pop_front();
			checked++;
			compare_field("status", got.status, want.status);
			compare_field("item_key", got.item_key, want.item_key);
			compare_field("item_score", got.item_score, want.item_score);
			compare_field("position", got.position, want.position);
			compare_field("head_key", got.head_key, want.head_key);
			compare_field("tail_key", got.tail_key, want.tail_key);
			compare_field("is_empty", got.is_empty, want.is_empty);
			compare_field("entry_count", got.entry_count, want.entry_count);
			compare_field("max_score", got.max_score, want.max_score);
			compare_field("last", got.last, want.last);
		endtask
	endclass

	logic  clk = 1'b0;
	logic  arst_n = 1'b0;
	logic  req_valid = 1'b0;
	req_t  req = '0;
	logic  rsp_stall = 1'b0;
	logic  req_stall;
	logic  rsp_valid;
	rsp_t  rsp;
	int    send_idle_pct = 0;
	int    recv_stall_pct = 0;
	int    cycle_count = 0;

	record_tracker tracker = new();

	record_fifo_with_search_max_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still due",
				cycle_count, tracker.due_results.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	always @(negedge clk) begin
		rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall)
			tracker.check_result(rsp);
	end

	// one beat: optional idle cycles, then hold until the block takes it
	task automatic send_beat(act_t a, logic [31:0] k, logic signed [15:0] s);
		req_t item;
		item.action = a;
		item.key = k;
		item.score = s;
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		req <= item;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		tracker.note_action(item);
	endtask

	function automatic act_t pick_action(int kind);
		int roll;
		int push_w;
		int pop_w;
		int srch_w;
		roll = $urandom_range(0, 99);
		case (kind)
			0: begin push_w = 80; pop_w = 4;  srch_w = 12; end
			1: begin push_w = 20; pop_w = 60; srch_w = 15; end
			2: begin push_w = 35; pop_w = 30; srch_w = 30; end
			default: begin push_w = 55; pop_w = 5; srch_w = 35; end
		endcase
		if (roll < push_w)
			return ACT_PUSH;
		else if (roll < push_w + pop_w)
			return ACT_POP;
		else if (roll < push_w + pop_w + srch_w)
			return ACT_SEARCH;
		return ACT_NOP;
	endfunction

	// small key pool so that searches hit, often several times
	function automatic logic [31:0] pick_key(int pool_size);
		if ($urandom_range(0, 9) < 8) begin
			case ($urandom_range(0, pool_size - 1))
				0: return 32'h0000_0000;
				1: return 32'hFFFF_FFFF;
				2: return 32'h1234_5678;
				default: return 32'h8000_0001;
			endcase
		end
		return $urandom;
	endfunction

	function automatic logic signed [15:0] pick_score();
		case ($urandom_range(0, 7))
			0, 1: return 16'(-1003 + int'($urandom_range(0, 6)));
			2: return 16'(-32768 + int'($urandom_range(0, 31767)));
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic run_bursts(int n_items, bit fill_first);
		int sent;
		int kind;
		int burst_len;
		sent = 0;
		while (sent < n_items) begin
			kind = fill_first && sent == 0 ? 0 : int'($urandom_range(0, 3));
			burst_len = $urandom_range(16, 40);
			for (int j = 0; j < burst_len && sent < n_items; j++) begin
				send_beat(pick_action(kind), pick_key(kind == 3 ? 1 : 4), pick_score());
				sent++;
			end
		end
	endtask

	initial begin
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;

		// empty queue corners, key and score extremes, floor of the maximum
		send_beat(ACT_POP, 32'h0, 16'sh0);
		send_beat(ACT_SEARCH, 32'hFFFF_FFFF, 16'sh0);
		send_beat(ACT_NOP, 32'h0, 16'sh0);
		send_beat(ACT_PUSH, 32'h0000_0000, 16'sh8000);
		send_beat(ACT_PUSH, 32'hFFFF_FFFF, 16'sh7FFF);
		send_beat(ACT_PUSH, 32'h0000_0000, -16'sd1001);
		send_beat(ACT_SEARCH, 32'h0000_0000, 16'sh0);
		send_beat(ACT_SEARCH, 32'h1234_5678, 16'sh0);
		send_beat(ACT_NOP, 32'hDEAD_BEEF, -16'sd1);
		send_beat(ACT_POP, 32'h0, 16'sh0);
		send_beat(ACT_SEARCH, 32'hFFFF_FFFF, 16'sh0);
		send_beat(ACT_POP, 32'h0, 16'sh0);
		send_beat(ACT_POP, 32'h0, 16'sh0);
		send_beat(ACT_POP, 32'h0, 16'sh0);
		send_beat(ACT_PUSH, 32'hA5A5_A5A5, -16'sd1000);
		send_beat(ACT_PUSH, 32'h5A5A_5A5A, -16'sd1001);
		send_beat(ACT_SEARCH, 32'h5A5A_5A5A, 16'sh0);
		send_beat(ACT_POP, 32'h0, 16'sh0);
		send_beat(ACT_POP, 32'h0, 16'sh0);

		send_idle_pct = 24;
		recv_stall_pct = 53;
		run_bursts(RANDOM_PER_PHASE, 1'b1);
		send_idle_pct = 53;
		recv_stall_pct = 24;
		run_bursts(RANDOM_PER_PHASE, 1'b0);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		run_bursts(RANDOM_PER_PHASE, 1'b0);

		@(negedge clk);
		req_valid <= 1'b0;
		while (tracker.due_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("ran %0d push, %0d pop, %0d search and %0d no-op beats; %0d results checked",
			tracker.action_hits[ACT_PUSH], tracker.action_hits[ACT_POP],
			tracker.action_hits[ACT_SEARCH], tracker.action_hits[ACT_NOP], tracker.checked);
		$display("push on full queue %0d times, key absent %0d times, up to %0d hits per search",
			tracker.full_hits, tracker.absent_hits, tracker.most_matches);
		if (tracker.fail_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

[sim.f]
+incdir+sv
sv/rfs_pkg.sv
sv/rfs_ctrl.sv
sv/rfs_dp.sv
sv/record_fifo_with_search_max_top.sv
tb/sv/record_fifo_with_search_max_top_tb.sv
